// ----- design/mgls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgls_pkg
// Shared widths, fixed-point constants and the 2^-x table for the Metropolis
// gap lattice step.
// ----------------------------------------------------------------------------
package mgls_pkg;

    localparam int SITE_W    = 6;
    localparam int RND_W     = 16;
    localparam int GAP_W     = 24;
    localparam int DELTA_W   = 23;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELTA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUART = 3'd6;

    // window sum: up to 49 gaps of 24 bits
    localparam int WSUM_W = 30;

    // shared multiplier operands and product
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = 64;

    // divider: (dE << 16) / temperature
    localparam int DIV_N_W = 39;
    localparam int DIV_D_W = 23;

    localparam int EXP_K_MAX = 32;

    localparam logic signed [PROD_W-1:0] RND_HALF    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] WIDE_LIM    = 64'sd274877906943;
    localparam logic signed [PROD_W-1:0] GAP_MAX     = 64'sd8388607;
    localparam logic signed [PROD_W-1:0] GAP_MIN     = -64'sd8388608;
    localparam logic signed [PROD_W-1:0] EXP_Y_LIMIT = 64'sd33 <<< FRAC_BITS;
    localparam logic signed [MUL_B_W-1:0] LOG2E_Q16  = 33'sd94548;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // 2^(-i/16) in Q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        case (idx)
            5'd0:    return 17'd65536;
            5'd1:    return 17'd62757;
            5'd2:    return 17'd60097;
            5'd3:    return 17'd57549;
            5'd4:    return 17'd55109;
            5'd5:    return 17'd52773;
            5'd6:    return 17'd50535;
            5'd7:    return 17'd48393;
            5'd8:    return 17'd46341;
            5'd9:    return 17'd44376;
            5'd10:   return 17'd42495;
            5'd11:   return 17'd40693;
            5'd12:   return 17'd38968;
            5'd13:   return 17'd37316;
            5'd14:   return 17'd35734;
            5'd15:   return 17'd34219;
            default: return 17'd32768;
        endcase
    endfunction

endpackage

// ----- design/mgls_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgls_mul
// Shared signed multiplier, 42 x 33 bits, built from one 22 x 33 multiplier
// used twice, low half first. The registered product is flagged by done.
// ----------------------------------------------------------------------------
module mgls_mul
    import mgls_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                      done,
    output logic signed [PROD_W-1:0]  prod
);

    localparam int HALF_W = MUL_A_W / 2;
    localparam int PP_W   = HALF_W + 1 + MUL_B_W;
    localparam int SUM_W  = PP_W + HALF_W;

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic [1:0]                ph_reg;
    logic                      done_reg;
    logic signed [PP_W-1:0]    lo_reg;
    logic signed [PP_W-1:0]    hi_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [HALF_W:0]    mx;
    logic signed [PP_W-1:0]    pp;
    logic signed [SUM_W-1:0]   sum;

    assign mx  = (ph_reg == 2'd1) ? $signed({1'b0, a_reg[HALF_W-1:0]})
                                  : $signed({a_reg[MUL_A_W-1], a_reg[MUL_A_W-1:HALF_W]});
    assign pp  = mx * b_reg;
    assign sum = $signed({hi_reg, {HALF_W{1'b0}}}) + SUM_W'(lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            ph_reg   <= 2'd0;
            done_reg <= 1'b0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            prod_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg  <= a;
                b_reg  <= b;
                ph_reg <= 2'd1;
            end
            else
            begin
                case (ph_reg)
                    2'd1:
                    begin
                        lo_reg <= pp;
                        ph_reg <= 2'd2;
                    end
                    2'd2:
                    begin
                        hi_reg <= pp;
                        ph_reg <= 2'd3;
                    end
                    2'd3:
                    begin
                        prod_reg <= $signed(sum[PROD_W-1:0]);
                        done_reg <= 1'b1;
                        ph_reg   <= 2'd0;
                    end
                    default:
                    begin
                        ph_reg <= 2'd0;
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- design/mgls_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgls_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mgls_div
    import mgls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIV_N_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DIV_D_W'(trial - {1'b0, dsr_reg}) : trial[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/metropolis_gap_lattice_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metropolis_gap_lattice_step_core
// One Metropolis update of a ROWS x COLS lattice of Q8.16 gaps per transaction.
// ----------------------------------------------------------------------------
// After reset the lattice memory is swept to zero, one entry per cycle;
// no input transaction is taken until the sweep ends, configuration writes
// are taken at any time. Items are processed one at a time. Each item reads
// its (2r+1)^2 window from the lattice memory (one read and one write port)
// one entry per cycle, then evaluates the free energy twice on one shared
// multiplier (up to 18 products). When dE > 0 and the temperature is
// nonzero, a bit-serial divide and one more exp evaluation follow. A
// finished result sits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module metropolis_gap_lattice_step_core
    import mgls_pkg::*;
#(
    parameter int ROWS      = 64,
    parameter int COLS      = 64,
    parameter int MAX_RANGE = 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SITE_W-1:0]       site_row,
    input  logic [SITE_W-1:0]       site_col,
    input  logic                    direction,
    input  logic [RND_W-1:0]        accept_random,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    accepted,
    output logic signed [GAP_W-1:0] new_gap,
    output logic signed [GAP_W-1:0] energy_change,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int RCW   = ((RW > SITE_W) ? RW : SITE_W) + 1;
    localparam int CCW   = ((CW > SITE_W) ? CW : SITE_W) + 1;

    localparam logic [AW-1:0]  COLS_A = AW'(COLS);
    localparam logic [AW-1:0]  LAST_A = AW'(DEPTH - 1);
    localparam logic [RCW-1:0] ROWS_R = RCW'(ROWS);
    localparam logic [CCW-1:0] COLS_R = CCW'(COLS);
    localparam logic [RW:0]    ROWS_X = (RW + 1)'(ROWS);
    localparam logic [CW:0]    COLS_X = (CW + 1)'(COLS);
    localparam logic [RW-1:0]  ROW_END = RW'(ROWS - 1);
    localparam logic [CW-1:0]  COL_END = CW'(COLS - 1);
    localparam logic [2:0]     MAXR    = 3'(MAX_RANGE);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RED     = 4'd2;
    localparam logic [3:0] S_SETUP   = 4'd3;
    localparam logic [3:0] S_WIN     = 4'd4;
    localparam logic [3:0] S_CTR     = 4'd5;
    localparam logic [3:0] S_CTRW    = 4'd6;
    localparam logic [3:0] S_G1      = 4'd7;
    localparam logic [3:0] S_MSTART  = 4'd8;
    localparam logic [3:0] S_MWAIT   = 4'd9;
    localparam logic [3:0] S_DECIDE  = 4'd10;
    localparam logic [3:0] S_DIVW    = 4'd11;
    localparam logic [3:0] S_EXPDONE = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam logic [3:0] OP_G2    = 4'd0;
    localparam logic [3:0] OP_FORCE = 4'd1;
    localparam logic [3:0] OP_T     = 4'd2;
    localparam logic [3:0] OP_INTER = 4'd3;
    localparam logic [3:0] OP_EXPY  = 4'd4;
    localparam logic [3:0] OP_EXPM  = 4'd5;
    localparam logic [3:0] OP_COH   = 4'd6;
    localparam logic [3:0] OP_G4    = 4'd7;
    localparam logic [3:0] OP_QUART = 4'd8;

    // configuration
    logic [DELTA_W-1:0]      delta_reg;
    logic [DELTA_W-1:0]      temp_reg;
    logic signed [CFG_W-1:0] force_reg;
    logic signed [CFG_W-1:0] inter_reg;
    logic [1:0]              range_reg;
    logic signed [CFG_W-1:0] coh_reg;
    logic signed [CFG_W-1:0] quart_reg;

    // control and datapath
    logic [3:0]               state_reg;
    logic [3:0]               op_reg;
    logic [AW-1:0]            clr_reg;
    logic [RCW-1:0]           row_reg;
    logic [CCW-1:0]           col_reg;
    logic                     dir_reg;
    logic [RND_W-1:0]         rnd_reg;
    logic [RW-1:0]            rr_reg;
    logic [CW-1:0]            cc_reg;
    logic [CW-1:0]            cstart_reg;
    logic [2:0]               wi_reg;
    logic [2:0]               wj_reg;
    logic                     pend_reg;
    logic signed [WSUM_W-1:0] wsum_reg;
    logic signed [GAP_W-1:0]  g0_reg;
    logic signed [GAP_W-1:0]  g1_reg;
    logic                     second_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic [30:0]              g2_reg;
    logic signed [38:0]       t_reg;
    logic [38:0]              g4_reg;
    logic [39:0]              ex_x_reg;
    logic [5:0]               ex_k_reg;
    logic [16:0]              ex_lo_reg;
    logic [16:0]              ex_hi_reg;
    logic [11:0]              ex_rem_reg;
    logic [16:0]              e_reg;
    logic                     exp_acc_reg;
    logic                     take_reg;
    logic signed [GAP_W-1:0]  de_reg;

    logic                     out_valid_reg;
    logic                     accepted_reg;
    logic signed [GAP_W-1:0]  new_gap_reg;
    logic signed [GAP_W-1:0]  energy_reg;

    // lattice memory
    logic [GAP_W-1:0] gap_mem [DEPTH];
    logic [GAP_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [GAP_W-1:0] wr_data;
    logic             wr_en;

    // combinational helpers
    logic [1:0]               r_eff;
    logic [2:0]               wspan;
    logic [RW-1:0]            row_idx;
    logic [CW-1:0]            col_idx;
    logic [RW:0]              row_x;
    logic [CW:0]              col_x;
    logic [RW-1:0]            row_start;
    logic [CW-1:0]            col_start;
    logic [RW-1:0]            rr_step;
    logic [CW-1:0]            cc_step;
    logic [AW-1:0]            site_addr;
    logic [AW-1:0]            win_addr;
    logic signed [GAP_W:0]    g1_sum;
    logic signed [GAP_W-1:0]  g1_sat;
    logic signed [GAP_W-1:0]  g_cur;
    logic signed [30:0]       wdiff;
    logic signed [17:0]       ex_diff;
    logic signed [17:0]       one_minus_e;
    logic signed [PROD_W-1:0] r16;
    logic signed [PROD_W-1:0] r12;
    logic signed [PROD_W-1:0] term;
    logic signed [PROD_W-1:0] t_clamp;
    logic signed [PROD_W-1:0] g4_clamp;
    logic signed [GAP_W-1:0]  de_sat;
    logic [16:0]              ex_m;
    logic [5:0]               ex_km1;
    logic [16:0]              ex_t1;
    logic [17:0]              ex_t2;
    logic [16:0]              e_val;
    logic out_free;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;

    logic                      div_start;
    logic                      div_done;
    logic [DIV_N_W-1:0]        div_quo;

    assign r_eff   = ({1'b0, range_reg} > MAXR) ? MAXR[1:0] : range_reg;
    assign wspan   = {r_eff, 1'b0};
    assign row_idx = row_reg[RW-1:0];
    assign col_idx = col_reg[CW-1:0];
    assign row_x   = {1'b0, row_idx};
    assign col_x   = {1'b0, col_idx};

    // window start, wrapping below zero
    assign row_start = (row_x >= (RW + 1)'(r_eff)) ? RW'(row_x - (RW + 1)'(r_eff))
                                                   : RW'(row_x + ROWS_X - (RW + 1)'(r_eff));
    assign col_start = (col_x >= (CW + 1)'(r_eff)) ? CW'(col_x - (CW + 1)'(r_eff))
                                                   : CW'(col_x + COLS_X - (CW + 1)'(r_eff));
    assign rr_step   = (rr_reg == ROW_END) ? '0 : rr_reg + 1'b1;
    assign cc_step   = (cc_reg == COL_END) ? '0 : cc_reg + 1'b1;
    assign site_addr = AW'(row_idx) * COLS_A + AW'(col_idx);
    assign win_addr  = AW'(rr_reg) * COLS_A + AW'(cc_reg);

    assign g1_sum = dir_reg ? ((GAP_W + 1)'(g0_reg) + $signed({2'b0, delta_reg}))
                            : ((GAP_W + 1)'(g0_reg) - $signed({2'b0, delta_reg}));
    assign g1_sat = (g1_sum > (GAP_W + 1)'(GAP_MAX)) ? GAP_MAX[GAP_W-1:0] :
                    (g1_sum < (GAP_W + 1)'(GAP_MIN)) ? GAP_MIN[GAP_W-1:0] :
                    g1_sum[GAP_W-1:0];

    assign g_cur       = second_reg ? g0_reg : g1_reg;
    assign wdiff       = 31'(wsum_reg) - 31'(g_cur);
    assign ex_diff     = $signed({1'b0, ex_lo_reg}) - $signed({1'b0, ex_hi_reg});
    assign one_minus_e = $signed({1'b0, ONE_Q16}) - $signed({1'b0, e_reg});

    always_comb
    begin
        case (op_reg)
            OP_G2:
            begin
                mul_a = MUL_A_W'(g_cur);
                mul_b = MUL_B_W'(g_cur);
            end
            OP_FORCE:
            begin
                mul_a = MUL_A_W'(g_cur);
                mul_b = MUL_B_W'(force_reg);
            end
            OP_T:
            begin
                mul_a = MUL_A_W'(wdiff);
                mul_b = MUL_B_W'(g_cur);
            end
            OP_INTER:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(inter_reg);
            end
            OP_EXPY:
            begin
                mul_a = $signed({2'b0, ex_x_reg});
                mul_b = LOG2E_Q16;
            end
            OP_EXPM:
            begin
                mul_a = MUL_A_W'(ex_diff);
                mul_b = $signed({21'b0, ex_rem_reg});
            end
            OP_COH:
            begin
                mul_a = MUL_A_W'(one_minus_e);
                mul_b = MUL_B_W'(coh_reg);
            end
            OP_G4:
            begin
                mul_a = $signed({11'b0, g2_reg});
                mul_b = $signed({2'b0, g2_reg});
            end
            OP_QUART:
            begin
                mul_a = $signed({3'b0, g4_reg});
                mul_b = MUL_B_W'(quart_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product scaled back to Q16, rounded half up
    assign r16 = (mul_prod + RND_HALF) >>> FRAC_BITS;
    assign r12 = (mul_prod + 64'sd2048) >>> 12;

    always_comb
    begin
        case (op_reg)
            OP_INTER: term = (r16 + 64'sd1) >>> 1;
            OP_COH:   term = r16 <<< 1;
            default:  term = r16;
        endcase
    end

    assign t_clamp  = (r16 > WIDE_LIM) ? WIDE_LIM : ((r16 < -WIDE_LIM) ? -WIDE_LIM : r16);
    assign g4_clamp = (r16 > WIDE_LIM) ? WIDE_LIM : r16;
    assign de_sat   = (acc_reg > GAP_MAX) ? GAP_MAX[GAP_W-1:0] :
                      (acc_reg < GAP_MIN) ? GAP_MIN[GAP_W-1:0] :
                      acc_reg[GAP_W-1:0];

    // interpolated mantissa, then shift right by k with rounding
    assign ex_m   = ex_lo_reg - r12[16:0];
    assign ex_km1 = ex_k_reg - 6'd1;
    assign ex_t1  = ex_m >> ex_km1;
    assign ex_t2  = {1'b0, ex_t1} + 18'd1;
    assign e_val  = (ex_k_reg == 6'd0) ? ex_m : ex_t2[17:1];

    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_start = (state_reg == S_MSTART);
    assign div_start = (state_reg == S_DECIDE) && (acc_reg > 64'sd0) && (temp_reg != '0);

    mgls_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    mgls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({de_sat[DIV_D_W-1:0], {FRAC_BITS{1'b0}}}),
        .divisor  (temp_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // memory ports
    assign rd_addr = (state_reg == S_WIN) ? win_addr : site_addr;
    assign wr_en   = (state_reg == S_CLEAR) || ((state_reg == S_OUT) && out_free && take_reg);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : site_addr;
    assign wr_data = (state_reg == S_CLEAR) ? '0 : g1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= gap_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= 23'd6554;
            temp_reg  <= 23'd65536;
            force_reg <= '0;
            inter_reg <= '0;
            range_reg <= 2'd1;
            coh_reg   <= '0;
            quart_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DELTA: delta_reg <= cfg_data[DELTA_W-1:0];
                REG_TEMP:  temp_reg  <= cfg_data[DELTA_W-1:0];
                REG_FORCE: force_reg <= $signed(cfg_data);
                REG_INTER: inter_reg <= $signed(cfg_data);
                REG_RANGE: range_reg <= cfg_data[1:0];
                REG_COH:   coh_reg   <= $signed(cfg_data);
                REG_QUART: quart_reg <= $signed(cfg_data);
                default:   ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            op_reg        <= OP_G2;
            clr_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            dir_reg       <= 1'b0;
            rnd_reg       <= '0;
            rr_reg        <= '0;
            cc_reg        <= '0;
            cstart_reg    <= '0;
            wi_reg        <= '0;
            wj_reg        <= '0;
            pend_reg      <= 1'b0;
            wsum_reg      <= '0;
            g0_reg        <= '0;
            g1_reg        <= '0;
            second_reg    <= 1'b0;
            acc_reg       <= '0;
            g2_reg        <= '0;
            t_reg         <= '0;
            g4_reg        <= '0;
            ex_x_reg      <= '0;
            ex_k_reg      <= '0;
            ex_lo_reg     <= '0;
            ex_hi_reg     <= '0;
            ex_rem_reg    <= '0;
            e_reg         <= '0;
            exp_acc_reg   <= 1'b0;
            take_reg      <= 1'b0;
            de_reg        <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
            new_gap_reg   <= '0;
            energy_reg    <= '0;
        end
        else
        begin
            pend_reg <= (state_reg == S_WIN);
            if (pend_reg)
            begin
                wsum_reg <= wsum_reg + WSUM_W'($signed(rd_data_reg));
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_A)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        row_reg   <= RCW'(site_row);
                        col_reg   <= CCW'(site_col);
                        dir_reg   <= direction;
                        rnd_reg   <= accept_random;
                        state_reg <= S_RED;
                    end
                end
                S_RED:
                begin
                    // site index modulo lattice size
                    if (row_reg >= ROWS_R)
                    begin
                        row_reg <= row_reg - ROWS_R;
                    end
                    if (col_reg >= COLS_R)
                    begin
                        col_reg <= col_reg - COLS_R;
                    end
                    if ((row_reg < ROWS_R) && (col_reg < COLS_R))
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    rr_reg     <= row_start;
                    cc_reg     <= col_start;
                    cstart_reg <= col_start;
                    wi_reg     <= '0;
                    wj_reg     <= '0;
                    wsum_reg   <= '0;
                    state_reg  <= S_WIN;
                end
                S_WIN:
                begin
                    if (wj_reg == wspan)
                    begin
                        wj_reg <= '0;
                        cc_reg <= cstart_reg;
                        rr_reg <= rr_step;
                        wi_reg <= wi_reg + 1'b1;
                        if (wi_reg == wspan)
                        begin
                            state_reg <= S_CTR;
                        end
                    end
                    else
                    begin
                        wj_reg <= wj_reg + 1'b1;
                        cc_reg <= cc_step;
                    end
                end
                S_CTR:
                begin
                    state_reg <= S_CTRW;
                end
                S_CTRW:
                begin
                    g0_reg    <= $signed(rd_data_reg);
                    state_reg <= S_G1;
                end
                S_G1:
                begin
                    g1_reg      <= g1_sat;
                    second_reg  <= 1'b0;
                    acc_reg     <= '0;
                    exp_acc_reg <= 1'b0;
                    op_reg      <= OP_G2;
                    state_reg   <= S_MSTART;
                end
                S_MSTART:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_MSTART;
                        case (op_reg)
                            OP_G2:
                            begin
                                g2_reg <= r16[30:0];
                                op_reg <= OP_FORCE;
                            end
                            OP_FORCE:
                            begin
                                acc_reg <= second_reg ? acc_reg - term : acc_reg + term;
                                op_reg  <= OP_T;
                            end
                            OP_T:
                            begin
                                t_reg  <= $signed(t_clamp[38:0]);
                                op_reg <= OP_INTER;
                            end
                            OP_INTER:
                            begin
                                acc_reg  <= second_reg ? acc_reg - term : acc_reg + term;
                                ex_x_reg <= 40'(g2_reg);
                                if (g2_reg == '0)
                                begin
                                    e_reg     <= ONE_Q16;
                                    state_reg <= S_EXPDONE;
                                end
                                else
                                begin
                                    op_reg <= OP_EXPY;
                                end
                            end
                            OP_EXPY:
                            begin
                                if (r16 >= EXP_Y_LIMIT)
                                begin
                                    e_reg     <= '0;
                                    state_reg <= S_EXPDONE;
                                end
                                else
                                begin
                                    ex_k_reg   <= r16[21:16];
                                    ex_lo_reg  <= pow2_neg({1'b0, r16[15:12]});
                                    ex_hi_reg  <= pow2_neg({1'b0, r16[15:12]} + 5'd1);
                                    ex_rem_reg <= r16[11:0];
                                    op_reg     <= OP_EXPM;
                                end
                            end
                            OP_EXPM:
                            begin
                                e_reg     <= e_val;
                                state_reg <= S_EXPDONE;
                            end
                            OP_COH:
                            begin
                                acc_reg <= second_reg ? acc_reg - term : acc_reg + term;
                                op_reg  <= OP_G4;
                            end
                            OP_G4:
                            begin
                                g4_reg <= g4_clamp[38:0];
                                op_reg <= OP_QUART;
                            end
                            OP_QUART:
                            begin
                                acc_reg <= second_reg ? acc_reg - term : acc_reg + term;
                                if (!second_reg)
                                begin
                                    second_reg <= 1'b1;
                                    op_reg     <= OP_G2;
                                end
                                else
                                begin
                                    state_reg <= S_DECIDE;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DECIDE;
                            end
                        endcase
                    end
                end
                S_DECIDE:
                begin
                    de_reg <= de_sat;
                    if (acc_reg <= 64'sd0)
                    begin
                        take_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (temp_reg == '0)
                    begin
                        take_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        exp_acc_reg <= 1'b1;
                        ex_x_reg    <= 40'(div_quo);
                        if (div_quo == '0)
                        begin
                            e_reg     <= ONE_Q16;
                            state_reg <= S_EXPDONE;
                        end
                        else
                        begin
                            op_reg    <= OP_EXPY;
                            state_reg <= S_MSTART;
                        end
                    end
                end
                S_EXPDONE:
                begin
                    if (exp_acc_reg)
                    begin
                        take_reg  <= ({1'b0, rnd_reg} < e_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        op_reg    <= OP_COH;
                        state_reg <= S_MSTART;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        accepted_reg  <= take_reg;
                        new_gap_reg   <= take_reg ? g1_reg : g0_reg;
                        energy_reg    <= de_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign new_gap       = new_gap_reg;
    assign energy_change = energy_reg;

endmodule
